// ===== rtl/core/tfe_pkg.sv =====
package tfe_pkg;

  // field and register widths
  localparam int MODE_W  = 2;
  localparam int K_W     = 5;
  localparam int CHROM_W = 13;
  localparam int FIT_W   = 29;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // q16 values: table entries stay below 1.0, block values may equal it
  localparam int TAB_W = 16;
  localparam int VAL_W = 17;

  localparam logic [VAL_W-1:0] Q_ONE      = VAL_W'(65536);
  localparam logic [VAL_W-1:0] Q_POINT4   = VAL_W'(26214);
  localparam logic [VAL_W-1:0] Q_POINT8   = VAL_W'(52428);
  localparam logic [FIT_W-1:0] FIT_CAP    = {FIT_W{1'b1}};
  localparam logic [K_W-1:0]   SIX_K      = K_W'(6);
  localparam logic [K_W-1:0]   MIN_K      = K_W'(2);

  // 0.8 * 65536 * 5 = 2^18, divided once by 5*(k-1) to seed the table
  localparam int NUM_LOG2  = 18;
  localparam int DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(NUM_LOG2 + 1);

  localparam int DEF_MAX_LEN = 4096;
  localparam int DEF_MAX_K   = 16;

  localparam logic [MODE_W-1:0] MODE_ONEMAX = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CONCAT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SIX    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CYCLIC = 2'd3;

  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_TRAPK = 2'd1;
  localparam logic [1:0] REG_CHROM = 2'd2;

  localparam logic [MODE_W-1:0]  RST_MODE  = MODE_CONCAT;
  localparam logic [K_W-1:0]     RST_TRAPK = K_W'(5);
  localparam logic [CHROM_W-1:0] RST_CHROM = CHROM_W'(100);

  typedef struct packed {
    logic init;
    logic div_step;
    logic fill_step;
    logic gene_take;
    logic wrap_add;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic fill_done;
    logic last_gene;
    logic need_wrap;
  } stat_t;

  function automatic logic [VAL_W-1:0] six_trap_value(input logic [K_W-1:0] u);
    logic [VAL_W-1:0] v;
    unique case (u)
      K_W'(0), K_W'(6): v = Q_ONE;
      K_W'(2), K_W'(4): v = Q_POINT4;
      K_W'(3):          v = Q_POINT8;
      default:          v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/tfe_ctrl.sv =====
module tfe_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wr,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  tfe_pkg::stat_t  stat,
  output tfe_pkg::cmd_t   cmd
);

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_FILL = 3'd2;
  localparam logic [2:0] S_RUN  = 3'd3;
  localparam logic [2:0] S_WRAP = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;
  logic       take;

  assign in_ready = (state == S_RUN) && (!out_valid || out_ready);
  assign take     = in_valid && in_ready;

  always_comb begin
    cmd.init      = (state == S_INIT);
    cmd.div_step  = (state == S_DIV) && !stat.div_done;
    cmd.fill_step = (state == S_FILL);
    cmd.gene_take = take;
    cmd.wrap_add  = (state == S_WRAP);
    cmd.finish    = (take && stat.last_gene && !stat.need_wrap) || (state == S_WRAP);
  end

  always_comb begin
    state_next = state;
    if (cfg_wr) begin
      state_next = S_INIT;
    end else begin
      unique case (state)
        S_INIT: state_next = S_DIV;
        S_DIV:  if (stat.div_done) state_next = S_FILL;
        S_FILL: if (stat.fill_done) state_next = S_RUN;
        S_RUN:  if (take && stat.last_gene && stat.need_wrap) state_next = S_WRAP;
        S_WRAP: state_next = S_RUN;
        default: state_next = S_INIT;
      endcase
    end
  end

  // result slot frees as it is taken, so a new result may land in the same cycle
  assign out_valid_next = cmd.finish || (out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== rtl/core/tfe_datapath.sv =====
module tfe_datapath #(
  parameter int MAX_LEN = tfe_pkg::DEF_MAX_LEN,
  parameter int MAX_K   = tfe_pkg::DEF_MAX_K
) (
  input  logic                          clk,
  input  tfe_pkg::cmd_t                 cmd,
  output tfe_pkg::stat_t                stat,
  input  logic [tfe_pkg::MODE_W-1:0]    fitness_mode,
  input  logic [tfe_pkg::K_W-1:0]       trap_k,
  input  logic [tfe_pkg::CHROM_W-1:0]   chrom_length,
  input  logic                          gene_bit,
  output logic [tfe_pkg::FIT_W-1:0]     fitness
);

  localparam int KW     = tfe_pkg::K_W;
  localparam int TW     = tfe_pkg::TAB_W;
  localparam int VW     = tfe_pkg::VAL_W;
  localparam int FW     = tfe_pkg::FIT_W;
  localparam int TAB_AW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int DW     = $clog2(5 * (MAX_K - 1) + 1);
  localparam int LW     = $clog2(MAX_LEN + 1);
  localparam int PW     = $clog2(MAX_LEN);
  localparam int EW     = (LW > tfe_pkg::CHROM_W) ? LW : tfe_pkg::CHROM_W;

  // effective configuration
  logic [KW-1:0] k_eff;
  logic [KW-1:0] km1;
  logic [DW-1:0] d_val;
  logic [EW-1:0] chrom_ext;
  logic [LW-1:0] len_eff;

  always_comb begin
    if (trap_k < tfe_pkg::MIN_K) k_eff = tfe_pkg::MIN_K;
    else if (trap_k > KW'(MAX_K)) k_eff = KW'(MAX_K);
    else k_eff = trap_k;
  end

  assign km1   = k_eff - KW'(1);
  assign d_val = DW'({km1, 2'b00}) + DW'(km1);

  assign chrom_ext = EW'(chrom_length);
  always_comb begin
    if (chrom_ext == '0) len_eff = LW'(1);
    else if (chrom_ext > EW'(MAX_LEN)) len_eff = LW'(MAX_LEN);
    else len_eff = LW'(chrom_ext);
  end

  // seed divider: 2^18 / (5*(k-1)), one quotient bit per cycle
  logic [tfe_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [DW-1:0]                 rem;
  logic [TW-1:0]                 quo;
  logic [DW:0]                   rem_sh;
  logic                          rem_ge;

  assign rem_sh = {rem, (div_cnt == tfe_pkg::DIV_STEPS)};
  assign rem_ge = rem_sh >= {1'b0, d_val};

  // table fill: floor(j*2^18/d) by stepping quotient and remainder
  logic [TW-1:0] acc_q;
  logic [DW-1:0] acc_r;
  logic [DW:0]   acc_sum;
  logic          acc_carry;
  logic [KW-1:0] fill_ptr;
  logic [TW-1:0] tab [MAX_K];

  assign acc_sum   = {1'b0, acc_r} + {1'b0, rem};
  assign acc_carry = acc_sum >= {1'b0, d_val};

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      div_cnt  <= tfe_pkg::DIV_STEPS;
      rem      <= '0;
      quo      <= '0;
      acc_q    <= '0;
      acc_r    <= '0;
      fill_ptr <= km1;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt - tfe_pkg::DIV_CNT_W'(1);
      rem     <= rem_ge ? DW'(rem_sh - {1'b0, d_val}) : DW'(rem_sh);
      quo     <= {quo[TW-2:0], rem_ge};
    end else if (cmd.fill_step) begin
      acc_q    <= acc_q + quo + TW'(acc_carry);
      acc_r    <= acc_carry ? DW'(acc_sum - {1'b0, d_val}) : DW'(acc_sum);
      fill_ptr <= fill_ptr - KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill_step) begin
      tab[fill_ptr[TAB_AW-1:0]] <= acc_q;
    end
  end

  // stream state
  logic [PW-1:0] pos;
  logic [KW-1:0] ones;
  logic [KW-1:0] bits;
  logic [FW-1:0] sum;
  logic          first_gene;

  logic [KW-1:0] ones_new;
  logic [KW-1:0] bits_new;
  logic [KW-1:0] ones_nx;
  logic [KW-1:0] bits_nx;
  logic          full;
  logic [KW-1:0] lk_u;
  logic [VW-1:0] trap_v;
  logic [VW-1:0] add_v;
  logic [FW:0]   sum_wide;
  logic [FW-1:0] sum_add;
  logic [LW-1:0] pos_new;
  logic          first_nx;

  assign ones_new = ones + KW'(gene_bit);
  assign bits_new = bits + KW'(1);
  assign full     = (fitness_mode == tfe_pkg::MODE_SIX) ? (bits_new >= tfe_pkg::SIX_K)
                                                        : (bits_new >= k_eff);

  // wrap block closes on gene 0
  assign lk_u = cmd.wrap_add ? (ones + KW'(first_gene)) : ones_new;

  always_comb begin
    if (lk_u == k_eff) trap_v = tfe_pkg::Q_ONE;
    else if (lk_u > k_eff) trap_v = '0;
    else trap_v = {1'b0, tab[lk_u[TAB_AW-1:0]]};
  end

  always_comb begin
    ones_nx = ones;
    bits_nx = bits;
    add_v   = '0;
    if (cmd.wrap_add) begin
      add_v = trap_v;
    end else begin
      unique case (fitness_mode)
        tfe_pkg::MODE_ONEMAX: add_v = gene_bit ? tfe_pkg::Q_ONE : '0;
        tfe_pkg::MODE_CONCAT: begin
          add_v   = full ? trap_v : '0;
          ones_nx = full ? '0 : ones_new;
          bits_nx = full ? '0 : bits_new;
        end
        tfe_pkg::MODE_SIX: begin
          add_v   = full ? tfe_pkg::six_trap_value(ones_new) : '0;
          ones_nx = full ? '0 : ones_new;
          bits_nx = full ? '0 : bits_new;
        end
        tfe_pkg::MODE_CYCLIC: begin
          // overlapping blocks: the closing gene opens the next block
          add_v   = full ? trap_v : '0;
          ones_nx = full ? KW'(gene_bit) : ones_new;
          bits_nx = full ? KW'(1) : bits_new;
        end
        default: add_v = '0;
      endcase
    end
  end

  assign sum_wide = {1'b0, sum} + (FW + 1)'(add_v);
  assign sum_add  = sum_wide[FW] ? tfe_pkg::FIT_CAP : sum_wide[FW-1:0];
  assign pos_new  = LW'(pos) + LW'(1);
  assign first_nx = (pos == '0) ? gene_bit : first_gene;

  assign stat.div_done  = (div_cnt == '0);
  assign stat.fill_done = (fill_ptr == '0);
  assign stat.last_gene = (pos_new >= len_eff);
  assign stat.need_wrap = (fitness_mode == tfe_pkg::MODE_CYCLIC) && (bits_nx == km1);

  always_ff @(posedge clk) begin
    if (cmd.init || cmd.finish) begin
      pos        <= '0;
      ones       <= '0;
      bits       <= '0;
      sum        <= '0;
      first_gene <= 1'b0;
    end else if (cmd.gene_take) begin
      pos        <= pos_new[PW-1:0];
      ones       <= ones_nx;
      bits       <= bits_nx;
      sum        <= sum_add;
      first_gene <= first_nx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      fitness <= sum_add;
    end
  end

endmodule

// ===== rtl/core/trap_fitness_evaluator.sv =====
// one gene per cycle while in_ready is high (a stalled result, a table rebuild
// or a wrap holds it low); result valid the cycle after the last gene is accepted,
// in cyclic mode after the wrap state when the last block wraps to gene 0
// after reset and after any register write the trap table is rebuilt with in_ready
// low by a bit-serial divider and a k-entry fill sweep, k = trap_k held to 2..MAX_K
// any register write drops the chromosome in progress; reset restores
// mode concatenated trap, trap_k 5, chrom_length 100
module trap_fitness_evaluator #(
  parameter int MAX_LEN = tfe_pkg::DEF_MAX_LEN,
  parameter int MAX_K   = tfe_pkg::DEF_MAX_K
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tfe_pkg::ADDR_W-1:0]    paddr,
  input  logic [tfe_pkg::DATA_W-1:0]    pwdata,
  output logic [tfe_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          gene_bit,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tfe_pkg::FIT_W-1:0]     fitness
);

  logic [tfe_pkg::MODE_W-1:0]  fitness_mode;
  logic [tfe_pkg::K_W-1:0]     trap_k;
  logic [tfe_pkg::CHROM_W-1:0] chrom_length;
  logic                        cfg_wr;
  logic [1:0]                  reg_idx;
  tfe_pkg::cmd_t               cmd;
  tfe_pkg::stat_t              stat;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      fitness_mode <= tfe_pkg::RST_MODE;
      trap_k       <= tfe_pkg::RST_TRAPK;
      chrom_length <= tfe_pkg::RST_CHROM;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        tfe_pkg::REG_MODE:  fitness_mode <= pwdata[tfe_pkg::MODE_W-1:0];
        tfe_pkg::REG_TRAPK: trap_k       <= pwdata[tfe_pkg::K_W-1:0];
        tfe_pkg::REG_CHROM: chrom_length <= pwdata[tfe_pkg::CHROM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      tfe_pkg::REG_MODE:  prdata = tfe_pkg::DATA_W'(fitness_mode);
      tfe_pkg::REG_TRAPK: prdata = tfe_pkg::DATA_W'(trap_k);
      tfe_pkg::REG_CHROM: prdata = tfe_pkg::DATA_W'(chrom_length);
      default:            prdata = '0;
    endcase
  end

  tfe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_wr),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tfe_datapath #(
    .MAX_LEN (MAX_LEN),
    .MAX_K   (MAX_K)
  ) u_datapath (
    .clk          (clk),
    .cmd          (cmd),
    .stat         (stat),
    .fitness_mode (fitness_mode),
    .trap_k       (trap_k),
    .chrom_length (chrom_length),
    .gene_bit     (gene_bit),
    .fitness      (fitness)
  );

  // table rebuild must hold off genes straight after a write
  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> !in_ready)
    else $error("gene request taken right after a register write");

  // a result only follows an accepted gene, directly or through the wrap state
  a_result_has_gene: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(in_valid && in_ready) || $past(in_valid && in_ready, 2)))
    else $error("result without a preceding gene request");

  // a pending result never gets overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("gene accepted while a result is stalled");

endmodule
